// ===== design/s2a_pkg.sv =====
// Shared types, constants and key tables for the scancode-to-ASCII translator.
// Used by s2a_emit and scancode_to_ascii_translator; depends on nothing.
package s2a_pkg;

  // Default number of table keys that are looked up
  localparam int MAP_ENTRIES_DEF = 58;
  localparam int MAP_KEYS        = 58;

  // Scancode set 1 codes
  localparam logic [7:0] SC_PREFIX = 8'hE0;
  localparam logic [7:0] SC_LSHIFT = 8'h2A;
  localparam logic [7:0] SC_RSHIFT = 8'h36;
  localparam logic [7:0] SC_LCTRL  = 8'h1D;
  localparam logic [7:0] SC_LALT   = 8'h38;
  localparam logic [7:0] SC_CAPS   = 8'h3A;
  localparam logic [7:0] SC_KEY1   = 8'h02;
  localparam logic [7:0] SC_KEY4   = 8'h05;
  localparam logic [7:0] SC_UP     = 8'h48;
  localparam logic [7:0] SC_DOWN   = 8'h50;
  localparam logic [7:0] SC_RIGHT  = 8'h4D;
  localparam logic [7:0] SC_LEFT   = 8'h4B;
  localparam logic [7:0] SC_HOME   = 8'h47;
  localparam logic [7:0] SC_END    = 8'h4F;
  localparam logic [7:0] SC_DEL    = 8'h53;
  localparam logic [7:0] SC_BREAK  = 8'h80;

  // ASCII characters used in escape sequences and case folding
  localparam logic [6:0] CH_ESC    = 7'h1B;
  localparam logic [6:0] CH_LBRACK = 7'h5B;
  localparam logic [6:0] CH_THREE  = 7'h33;
  localparam logic [6:0] CH_TILDE  = 7'h7E;
  localparam logic [6:0] CH_A_UP   = 7'h41;
  localparam logic [6:0] CH_B_UP   = 7'h42;
  localparam logic [6:0] CH_C_UP   = 7'h43;
  localparam logic [6:0] CH_D_UP   = 7'h44;
  localparam logic [6:0] CH_F_UP   = 7'h46;
  localparam logic [6:0] CH_H_UP   = 7'h48;
  localparam logic [6:0] CH_A_LOW  = 7'h61;
  localparam logic [6:0] CH_Z_LOW  = 7'h7A;
  localparam logic [6:0] CASE_DIFF = 7'h20;

  // Result kinds
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_TERM = 1'b1;

  // US QWERTY layout, unshifted
  localparam logic [6:0] PLAIN_MAP [0:MAP_KEYS-1] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08,
    7'h09, 7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69, 7'h6F,
    7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C,
    7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F,
    7'h00, 7'h2A, 7'h00, 7'h20
  };

  // US QWERTY layout, shifted
  localparam logic [6:0] SHIFT_MAP [0:MAP_KEYS-1] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
    7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08,
    7'h09, 7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49, 7'h4F,
    7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
    7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C,
    7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F,
    7'h00, 7'h2A, 7'h00, 7'h20
  };

  // Table read; keys past the defined layout hold zero
  function automatic logic [6:0] map_char(input logic [6:0] idx, input logic shifted);
    logic [6:0] c;
    c = 7'h00;
    if (idx < 7'(MAP_KEYS)) begin
      c = shifted ? SHIFT_MAP[idx[5:0]] : PLAIN_MAP[idx[5:0]];
    end
    return c;
  endfunction

  // One translated run handed to the emitter: up to four beats
  typedef struct packed {
    logic            kind;
    logic [3:0][6:0] chars;
    logic [1:0]      term;
    logic [1:0]      last;
  } job_t;

endpackage

// ===== design/s2a_emit.sv =====
// Output sequencer: holds one translated run and plays it out one beat a cycle while result_stall is low.
// Depends on s2a_pkg (job_t, result kinds).
module s2a_emit (
  input  logic           clk,
  input  logic           rst,
  input  s2a_pkg::job_t  job,
  input  logic           load,
  output logic           ready,
  output logic           result_valid,
  input  logic           result_stall,
  output logic           result_kind,
  output logic [6:0]     char_code,
  output logic [1:0]     terminal_index,
  output logic           last_of_run
);

  logic          busy;
  logic [1:0]    pos;
  s2a_pkg::job_t job_q;
  logic          at_last;

  assign at_last = (pos == job_q.last);

  // Free now, or the final beat of the current run leaves this cycle
  assign ready = !busy || (!result_stall && at_last);

  // Run control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= 2'd0;
    end else if (load) begin
      busy <= 1'b1;
      pos  <= 2'd0;
    end else if (busy && !result_stall) begin
      if (at_last) begin
        busy <= 1'b0;
      end else begin
        pos <= pos + 2'd1;
      end
    end
  end

  // Run payload
  always_ff @(posedge clk) begin
    if (load) begin
      job_q <= job;
    end
  end

  // Beat fields
  assign result_valid   = busy;
  assign result_kind    = job_q.kind;
  assign char_code      = (job_q.kind == s2a_pkg::KIND_TERM) ? 7'h00 : job_q.chars[pos];
  assign terminal_index = (job_q.kind == s2a_pkg::KIND_TERM) ? job_q.term : 2'd0;
  assign last_of_run    = at_last;

endmodule

// ===== design/scancode_to_ascii_translator.sv =====
// Top level of the scancode set 1 to ASCII translator.
// Depends on s2a_pkg and s2a_emit.
//
// Takes one set 1 scancode byte per beat and produces zero to four result beats:
// a character, a terminal switch (ctrl with keys 1 to 4), or an ANSI escape
// sequence for arrows, Home, End (three beats) and Delete (four beats).
// Shift, ctrl, caps lock and the 0xE0 prefix are tracked in flag registers
// cleared by reset. The key table is read into a register at accept; the first
// result beat passes the decode stage register and then the sequencer register.
// A single-beat key lets one scancode per cycle through while result_stall is
// low; an escape sequence holds the output sequencer, one beat per cycle while
// result_stall is low. Codes that give no result never reach the sequencer.
// Keys at or above MAP_ENTRIES give nothing.
module scancode_to_ascii_translator #(
  parameter int MAP_ENTRIES = s2a_pkg::MAP_ENTRIES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       scan_valid,
  output logic       scan_stall,
  input  logic [7:0] scan_code,
  output logic       result_valid,
  input  logic       result_stall,
  output logic       result_kind,
  output logic [6:0] char_code,
  output logic [1:0] terminal_index,
  output logic       last_of_run
);

  typedef enum logic [1:0] {
    OP_ESC3,
    OP_DEL,
    OP_TERM,
    OP_LOOKUP
  } op_t;

  localparam logic [8:0] MapLimit = 9'(MAP_ENTRIES);

  // Flags
  logic shift_held, ctrl_held, caps_on, prefix_pending;
  logic shift_held_next, ctrl_held_next, caps_on_next, prefix_pending_next;

  // Decode stage register
  logic       s1_valid;
  op_t        s1_op;
  logic [6:0] s1_letter;
  logic [1:0] s1_term;
  logic       s1_shift;
  logic       s1_caps;
  logic [6:0] map_q;

  // Decode results
  logic       dec_emit;
  op_t        dec_op;
  logic [6:0] dec_letter;
  logic       in_range;
  logic       accept;

  // Hand-off
  s2a_pkg::job_t job;
  logic          job_ok;
  logic          emit_ready;
  logic          emit_load;
  logic          s1_move;
  logic [6:0]    look_c;

  assign accept   = scan_valid && !scan_stall;
  assign in_range = ({1'b0, scan_code} < MapLimit);

  // Scancode decode and flag update
  always_comb begin
    shift_held_next     = shift_held;
    ctrl_held_next      = ctrl_held;
    caps_on_next        = caps_on;
    prefix_pending_next = prefix_pending;
    dec_emit            = 1'b0;
    dec_op              = OP_LOOKUP;
    dec_letter          = s2a_pkg::CH_A_UP;
    if (scan_code == s2a_pkg::SC_PREFIX) begin
      prefix_pending_next = 1'b1;
    end else if (prefix_pending) begin
      prefix_pending_next = 1'b0;
      if (scan_code[7] == 1'b0) begin
        unique case (scan_code)
          s2a_pkg::SC_UP: begin
            dec_emit = 1'b1; dec_op = OP_ESC3; dec_letter = s2a_pkg::CH_A_UP;
          end
          s2a_pkg::SC_DOWN: begin
            dec_emit = 1'b1; dec_op = OP_ESC3; dec_letter = s2a_pkg::CH_B_UP;
          end
          s2a_pkg::SC_RIGHT: begin
            dec_emit = 1'b1; dec_op = OP_ESC3; dec_letter = s2a_pkg::CH_C_UP;
          end
          s2a_pkg::SC_LEFT: begin
            dec_emit = 1'b1; dec_op = OP_ESC3; dec_letter = s2a_pkg::CH_D_UP;
          end
          s2a_pkg::SC_HOME: begin
            dec_emit = 1'b1; dec_op = OP_ESC3; dec_letter = s2a_pkg::CH_H_UP;
          end
          s2a_pkg::SC_END: begin
            dec_emit = 1'b1; dec_op = OP_ESC3; dec_letter = s2a_pkg::CH_F_UP;
          end
          s2a_pkg::SC_DEL: begin
            dec_emit = 1'b1; dec_op = OP_DEL;
          end
          default: begin
            dec_emit = 1'b0;
          end
        endcase
      end
    end else begin
      unique case (scan_code)
        s2a_pkg::SC_LSHIFT, s2a_pkg::SC_RSHIFT: begin
          shift_held_next = 1'b1;
        end
        s2a_pkg::SC_LSHIFT | s2a_pkg::SC_BREAK, s2a_pkg::SC_RSHIFT | s2a_pkg::SC_BREAK: begin
          shift_held_next = 1'b0;
        end
        s2a_pkg::SC_LCTRL: begin
          ctrl_held_next = 1'b1;
        end
        s2a_pkg::SC_LCTRL | s2a_pkg::SC_BREAK: begin
          ctrl_held_next = 1'b0;
        end
        s2a_pkg::SC_LALT, s2a_pkg::SC_LALT | s2a_pkg::SC_BREAK: begin
          dec_emit = 1'b0;
        end
        s2a_pkg::SC_CAPS: begin
          caps_on_next = !caps_on;
        end
        default: begin
          if (ctrl_held && scan_code >= s2a_pkg::SC_KEY1 && scan_code <= s2a_pkg::SC_KEY4) begin
            dec_emit = 1'b1;
            dec_op   = OP_TERM;
          end else begin
            dec_emit = in_range;
            dec_op   = OP_LOOKUP;
          end
        end
      endcase
    end
  end

  // Flags and decode stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held     <= 1'b0;
      ctrl_held      <= 1'b0;
      caps_on        <= 1'b0;
      prefix_pending <= 1'b0;
      s1_valid       <= 1'b0;
    end else begin
      if (accept) begin
        shift_held     <= shift_held_next;
        ctrl_held      <= ctrl_held_next;
        caps_on        <= caps_on_next;
        prefix_pending <= prefix_pending_next;
        s1_valid       <= dec_emit;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // Decode stage payload and registered table read
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op     <= dec_op;
      s1_letter <= dec_letter;
      s1_term   <= 2'(scan_code - s2a_pkg::SC_KEY1);
      s1_shift  <= shift_held;
      s1_caps   <= caps_on;
      map_q     <= s2a_pkg::map_char(scan_code[6:0], shift_held);
    end
  end

  // Caps lock folds lowercase letters only, and only when shift is up
  always_comb begin
    look_c = map_q;
    if (!s1_shift && s1_caps && map_q >= s2a_pkg::CH_A_LOW && map_q <= s2a_pkg::CH_Z_LOW) begin
      look_c = map_q - s2a_pkg::CASE_DIFF;
    end
  end

  // Build the run for the sequencer
  always_comb begin
    job.kind  = s2a_pkg::KIND_CHAR;
    job.chars = '0;
    job.term  = s1_term;
    job.last  = 2'd0;
    job_ok    = 1'b1;
    unique case (s1_op)
      OP_ESC3: begin
        job.chars[0] = s2a_pkg::CH_ESC;
        job.chars[1] = s2a_pkg::CH_LBRACK;
        job.chars[2] = s1_letter;
        job.last     = 2'd2;
      end
      OP_DEL: begin
        job.chars[0] = s2a_pkg::CH_ESC;
        job.chars[1] = s2a_pkg::CH_LBRACK;
        job.chars[2] = s2a_pkg::CH_THREE;
        job.chars[3] = s2a_pkg::CH_TILDE;
        job.last     = 2'd3;
      end
      OP_TERM: begin
        job.kind = s2a_pkg::KIND_TERM;
      end
      OP_LOOKUP: begin
        job.chars[0] = look_c;
        job_ok       = (look_c != 7'h00);
      end
      default: begin
        job_ok = 1'b0;
      end
    endcase
  end

  // A run with nothing to send drains without the sequencer
  assign s1_move    = s1_valid && (!job_ok || emit_ready);
  assign emit_load  = s1_valid && job_ok && emit_ready;
  assign scan_stall = s1_valid && !s1_move;

  s2a_emit u_emit (
    .clk            (clk),
    .rst            (rst),
    .job            (job),
    .load           (emit_load),
    .ready          (emit_ready),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .result_kind    (result_kind),
    .char_code      (char_code),
    .terminal_index (terminal_index),
    .last_of_run    (last_of_run)
  );

endmodule
